[rtl/core/gapf_pkg.sv]
package gapf_pkg;
    localparam int CoordW = 3;
    localparam int GridSide = 8;
    typedef logic [1:0] t_dir;
    localparam t_dir DirWest  = 2'd0;
    localparam t_dir DirNorth = 2'd1;
    localparam t_dir DirSouth = 2'd2;
    localparam t_dir DirEast  = 2'd3;
    localparam logic OpWrite = 1'b0;
    localparam logic OpQuery = 1'b1;
    localparam int MaxResults = 64;
endpackage

[rtl/core/grid_astar_path_finder.sv]
// A* path finder on an 8 x 8 map, four-connected, unit step cost, Manhattan
// heuristic. After reset the map is cleared one cell a cycle with o_stall
// high. A map write (op=0) leaves o_stall low. A query (op=1) holds o_stall
// high for its whole run: a sweep of the per-cell marks, then for each popped
// open entry a setup step, a scan of the open list for the lowest f, latest on
// ties, a compaction pass that moves the entries above the chosen one down a
// slot, an expand step and four neighbor checks, each a check, a read and an
// update step. A query with an off-grid cell gets the no-path answer without
// a search. A found path is traced back cell by cell and then sent start first,
// each word read and then loaded once the output word is free; a no-path answer
// is a single word. Input is taken again once the last word is loaded, even
// while that word waits. The open list scans take most of a query's run.
module grid_astar_path_finder #(
    parameter int OPEN_DEPTH = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [gapf_pkg::CoordW-1:0] i_cell_x,
    input  logic [gapf_pkg::CoordW-1:0] i_cell_y,
    input  logic                        i_cell_blocked,
    input  logic [gapf_pkg::CoordW-1:0] i_start_x,
    input  logic [gapf_pkg::CoordW-1:0] i_start_y,
    input  logic [gapf_pkg::CoordW-1:0] i_goal_x,
    input  logic [gapf_pkg::CoordW-1:0] i_goal_y,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [gapf_pkg::CoordW-1:0] o_step_x,
    output logic [gapf_pkg::CoordW-1:0] o_step_y,
    output logic                        o_found,
    output logic                        o_last
);
    import gapf_pkg::*;

    localparam int Ncells = GridSide * GridSide;
    localparam int Pw     = $clog2(GridSide);
    localparam int Cw     = 2 * Pw;
    localparam int Gw     = Cw + 1;
    localparam int Fw     = Gw + 1;
    localparam int Ow     = $clog2(OPEN_DEPTH);
    localparam int Ocw    = Ow + 1;
    localparam int Lw     = Cw + 1;
    localparam int Ew     = Cw + Fw;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_POP   = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_SHIFT = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_NB    = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_TRACE = 4'd8;
    localparam logic [3:0] S_TRC2  = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;
    localparam logic [3:0] S_EMRD  = 4'd11;
    localparam logic [3:0] S_NONE  = 4'd12;
    localparam logic [3:0] S_EXP   = 4'd13;
    localparam logic [3:0] S_RCLR  = 4'd14;

    logic [3:0] r_st;
    // memories
    logic              m_blk   [Ncells];
    logic [Gw-1:0]     m_cost  [Ncells];
    logic [1:0]        m_par   [Ncells];
    logic [Cw-1:0]     m_path  [Ncells];
    logic [Ew-1:0]     m_open  [OPEN_DEPTH];
    // per-cell marks, swept at query start
    logic [Ncells-1:0] r_seen, r_closed;

    logic [Cw-1:0]  r_start, r_goal, r_cur, r_nc, r_sel_c;
    logic [Pw-1:0]  r_gx, r_gy;
    logic [Gw-1:0]  r_gcur, r_g;
    logic [Fw-1:0]  r_sel_f;
    logic [Ocw-1:0] r_cnt;
    logic [Ocw-1:0] r_idx;
    logic [Ow-1:0]  r_sel;
    logic [Ew-1:0]  r_ord;
    logic [1:0]     r_d;
    logic [Lw-1:0]  r_len, r_k;
    logic           r_nb_ok;
    logic [Cw-1:0]  r_clr;
    logic           r_blk_rd;
    logic [Gw-1:0]  r_cost_rd;
    logic [1:0]     r_par_rd;
    logic [Cw-1:0]  r_path_rd;
    logic           r_ov;
    logic [Pw-1:0]  r_ox, r_oy;
    logic           r_of, r_ol;
    logic [Fw-1:0]  f_qs;
    logic [Fw-1:0]  r_fq;
    logic [Gw-1:0]  m_cost_q, r_cost_cur;

    assign f_qs = r_fq;

    logic accept_in;
    assign accept_in = i_valid && !o_stall;
    assign o_stall   = (r_st != S_IDLE);
    assign o_valid   = r_ov;
    assign o_step_x  = CoordW'(r_ox);
    assign o_step_y  = CoordW'(r_oy);
    assign o_found   = r_of;
    assign o_last    = r_ol;

    logic out_free;
    assign out_free = !r_ov || !i_stall;

    logic out_load;
    assign out_load = out_free && (r_st == S_EMRD || r_st == S_NONE);

    // coordinate helpers
    logic [Pw-1:0] cx, cy, nx, ny, hx, hy;
    logic          n_in;
    logic [Fw-1:0] fn;
    always_comb begin
        cx = r_cur[Pw-1:0];
        cy = r_cur[Cw-1:Pw];
        nx = cx; ny = cy; n_in = 1'b1;
        case (r_d)
            DirWest:  begin n_in = (cx != '0); nx = cx - 1'b1; end
            DirNorth: begin n_in = (cy != '0); ny = cy - 1'b1; end
            DirSouth: begin n_in = (cy < Pw'(GridSide - 1)); ny = cy + 1'b1; end
            DirEast:  begin n_in = (cx < Pw'(GridSide - 1)); nx = cx + 1'b1; end
            default:  n_in = 1'b0;
        endcase
        hx = (r_nc[Pw-1:0] > r_gx) ? r_nc[Pw-1:0] - r_gx : r_gx - r_nc[Pw-1:0];
        hy = (r_nc[Cw-1:Pw] > r_gy) ? r_nc[Cw-1:Pw] - r_gy : r_gy - r_nc[Cw-1:Pw];
        fn = Fw'(r_g) + Fw'(hx) + Fw'(hy);
    end

    logic [Fw-1:0] f_start;
    logic [Pw-1:0] sdx, sdy;
    always_comb begin
        sdx = (i_start_x[Pw-1:0] > i_goal_x[Pw-1:0]) ? i_start_x[Pw-1:0] - i_goal_x[Pw-1:0]
                                                     : i_goal_x[Pw-1:0] - i_start_x[Pw-1:0];
        sdy = (i_start_y[Pw-1:0] > i_goal_y[Pw-1:0]) ? i_start_y[Pw-1:0] - i_goal_y[Pw-1:0]
                                                     : i_goal_y[Pw-1:0] - i_start_y[Pw-1:0];
        f_start = Fw'(sdx) + Fw'(sdy);
    end

    logic off_grid;
    assign off_grid = (32'(i_start_x) >= GridSide) || (32'(i_start_y) >= GridSide)
                   || (32'(i_goal_x) >= GridSide) || (32'(i_goal_y) >= GridSide);

    logic [Cw-1:0] par_cell;
    logic          par_ok;
    always_comb begin
        par_cell = r_cur;
        par_ok   = 1'b1;
        case (r_par_rd)
            DirWest:  begin par_ok = (cx < Pw'(GridSide - 1));
                            par_cell[Pw-1:0] = cx + 1'b1; end
            DirNorth: begin par_ok = (cy < Pw'(GridSide - 1));
                            par_cell[Cw-1:Pw] = cy + 1'b1; end
            DirSouth: begin par_ok = (cy != '0); par_cell[Cw-1:Pw] = cy - 1'b1; end
            DirEast:  begin par_ok = (cx != '0); par_cell[Pw-1:0] = cx - 1'b1; end
            default:  par_ok = 1'b0;
        endcase
    end

    // open list scan: r_ord holds entry r_idx-1, the read address runs one ahead
    logic          scan_take;
    logic [Ow-1:0] idx_m1, scan_sel;
    assign idx_m1    = r_idx[Ow-1:0] - 1'b1;
    assign scan_take = (r_idx != '0) && (r_ord[Fw-1:0] <= r_sel_f);
    assign scan_sel  = scan_take ? idx_m1 : r_sel;

    // compaction: once r_idx has passed r_sel+1, entry r_idx-1 moves to slot r_idx-2
    logic sh_wr;
    assign sh_wr = (r_st == S_SHIFT) && (r_idx != Ocw'(r_sel) + Ocw'(1));

    logic push_ok;
    assign push_ok = r_nb_ok && !r_closed[r_nc] && !r_blk_rd
                  && !(r_seen[r_nc] && r_g >= r_cost_rd)
                  && (r_cnt < Ocw'(OPEN_DEPTH));

    // memory ports
    always_ff @(posedge i_clk) begin
        if (accept_in && i_op == OpWrite && !(32'(i_cell_x) >= GridSide)
                && !(32'(i_cell_y) >= GridSide)) begin
            m_blk[{i_cell_y[Pw-1:0], i_cell_x[Pw-1:0]}] <= i_cell_blocked;
        end else if (r_st == S_RCLR) begin
            m_blk[r_clr] <= 1'b0;
        end
        r_blk_rd  <= m_blk[r_nc];
        r_cost_rd <= m_cost[r_nc];
        r_par_rd  <= m_par[r_cur];
        r_path_rd <= m_path[r_k[Cw-1:0]];
        r_ord     <= m_open[r_idx[Ow-1:0]];
        if (r_st == S_CLR && r_clr == '1) begin
            m_cost[r_start] <= '0;
            m_par[r_start]  <= DirWest;
        end
        if (r_st == S_UPD && push_ok) begin
            m_cost[r_nc] <= r_g;
            m_par[r_nc]  <= r_d;
        end
        if (r_st == S_TRACE) m_path[r_len[Cw-1:0]] <= r_cur;
        if (r_st == S_CLR && r_clr == '1) m_open[0] <= {r_start, f_qs};
        else if (sh_wr) m_open[r_idx[Ow-1:0] - Ow'(2)] <= r_ord;
        else if (r_st == S_UPD && push_ok) m_open[r_cnt[Ow-1:0]] <= {r_nc, fn};
    end

    // cost of the selected cell, registered from m_cost and used when it is expanded
    always_ff @(posedge i_clk) r_cost_cur <= m_cost[r_sel_c];
    assign m_cost_q = r_cost_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_RCLR;
            r_ov <= 1'b0;
            r_seen <= '0;
            r_closed <= '0;
            r_clr <= '0;
            r_cnt <= '0;
        end else begin
            if (out_load) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            case (r_st)
                S_RCLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (accept_in && i_op == OpQuery) begin
                        r_start <= {i_start_y[Pw-1:0], i_start_x[Pw-1:0]};
                        r_goal  <= {i_goal_y[Pw-1:0], i_goal_x[Pw-1:0]};
                        r_gx    <= i_goal_x[Pw-1:0];
                        r_gy    <= i_goal_y[Pw-1:0];
                        r_fq    <= f_start;
                        r_clr   <= '0;
                        r_st    <= off_grid ? S_NONE : S_CLR;
                    end
                end
                S_CLR: begin
                    r_seen[r_clr]   <= (r_clr == r_start);
                    r_closed[r_clr] <= 1'b0;
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == '1) begin
                        r_cnt <= Ocw'(1);
                        r_st  <= S_POP;
                    end
                end
                S_POP: begin
                    if (r_cnt == '0) r_st <= S_NONE;
                    else begin
                        r_idx <= '0;
                        r_sel <= '0;
                        r_sel_f <= '1;
                        r_st  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_take) begin
                        r_sel_f <= r_ord[Fw-1:0];
                        r_sel_c <= r_ord[Ew-1:Fw];
                        r_sel   <= idx_m1;
                    end
                    if (r_idx == r_cnt) begin
                        r_idx <= Ocw'(scan_sel) + Ocw'(1);
                        r_st  <= S_SHIFT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SHIFT: begin
                    // move entries above the selected one down by one slot
                    if (r_idx >= r_cnt) begin
                        r_cnt <= r_cnt - 1'b1;
                        r_cur <= r_sel_c;
                        r_st  <= S_EXP;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EXP: begin
                    if (r_closed[r_cur]) r_st <= S_POP;
                    else if (r_cur == r_goal) begin
                        r_len <= '0;
                        r_st  <= S_TRACE;
                    end else begin
                        r_closed[r_cur] <= 1'b1;
                        r_gcur <= m_cost_q;
                        r_d  <= DirWest;
                        r_st <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_nc <= {ny, nx};
                    r_nb_ok <= n_in;
                    r_g <= r_gcur + 1'b1;
                    r_st <= S_NB;
                end
                S_NB: begin
                    r_st <= S_UPD;
                end
                S_UPD: begin
                    if (push_ok) begin
                        r_seen[r_nc] <= 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_d == DirEast) r_st <= S_POP;
                    else begin
                        r_d  <= r_d + 1'b1;
                        r_st <= S_CHK;
                    end
                end
                S_TRACE: begin
                    r_len <= r_len + 1'b1;
                    if (r_cur == r_start || r_len == Lw'(Ncells - 1)) r_st <= S_EMIT;
                    else r_st <= S_TRC2;
                    r_k <= r_len;
                end
                S_TRC2: begin
                    if (par_ok) begin
                        r_cur <= par_cell;
                        r_st  <= S_TRACE;
                    end else r_st <= S_EMIT;
                end
                S_EMIT: begin
                    r_st <= S_EMRD;
                end
                S_EMRD: begin
                    if (out_free) begin
                        r_ox <= r_path_rd[Pw-1:0];
                        r_oy <= r_path_rd[Cw-1:Pw];
                        r_of <= 1'b1;
                        r_ol <= (r_k == '0);
                        if (r_k == '0) r_st <= S_IDLE;
                        else begin
                            r_k  <= r_k - 1'b1;
                            r_st <= S_EMIT;
                        end
                    end
                end
                S_NONE: begin
                    if (out_free) begin
                        r_ox <= '0;
                        r_oy <= '0;
                        r_of <= 1'b0;
                        r_ol <= 1'b1;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> o_stall)
        else $error("input taken during query");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= Ocw'(OPEN_DEPTH))
        else $error("open count overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> (r_ov && $stable(r_ox) && $stable(r_ol)))
        else $error("stalled word changed");
endmodule

[verif/grid_astar_path_finder_tb.sv]
`timescale 1ns / 1ps

module grid_astar_path_finder_tb;
    import gapf_pkg::*;

    localparam int Side = 8;
    localparam int NCell = Side * Side;
    localparam int OpenMax = 256;
    localparam longint CycleLimit = 40000000;

    typedef struct packed {
        logic       op;
        logic [2:0] cx;
        logic [2:0] cy;
        logic       blk;
        logic [2:0] sx;
        logic [2:0] sy;
        logic [2:0] gx;
        logic [2:0] gy;
    } t_req;

    typedef struct packed {
        logic [2:0] x;
        logic [2:0] y;
        logic       found;
        logic       last;
    } t_step;

    localparam int ReqW = $bits(t_req);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_op = 1'b0;
    logic [2:0] i_cell_x = '0, i_cell_y = '0, i_start_x = '0, i_start_y = '0;
    logic [2:0] i_goal_x = '0, i_goal_y = '0;
    logic i_cell_blocked = 1'b0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [2:0] o_step_x, o_step_y;
    logic o_found, o_last;

    grid_astar_path_finder dut (.*);

    always #1 i_clk = ~i_clk;

    t_req   pending_reqs[$];
    t_step  expected_steps[$];
    logic   wall[NCell];
    int     errors = 0;
    longint cycles = 0;
    bit     stim_done = 0;

    task automatic add_req(input t_req r);
        pending_reqs = {pending_reqs, r};
    endtask

    function automatic int manh(int a, int b);
        int ddx, ddy;
        ddx = a % Side - b % Side;
        ddy = a / Side - b / Side;
        return (ddx < 0 ? -ddx : ddx) + (ddy < 0 ? -ddy : ddy);
    endfunction

    // A* search mirrored from the block's spec; appends the path words
    task automatic predict_path(input t_req r);
        int     cost[NCell];
        bit     seen[NCell], shut[NCell];
        t_dir   from[NCell];
        int     ocell[OpenMax], of[OpenMax];
        int     ocnt, sel, c, nc, g, nx, ny, st, gl, cur, len;
        int     trail[NCell];
        int     dx[4], dy[4];
        bit     done;
        t_step  s;
        dx = '{-1, 0, 0, 1};
        dy = '{0, -1, 1, 0};
        st = r.sy * Side + r.sx;
        gl = r.gy * Side + r.gx;
        foreach (seen[i]) begin
            seen[i] = 0;
            shut[i] = 0;
        end
        seen[st] = 1;
        cost[st] = 0;
        from[st] = DirWest;
        ocell[0] = st;
        of[0] = manh(st, gl);
        ocnt = 1;
        done = 0;
        while (ocnt > 0 && !done) begin
            sel = 0;
            for (int i = 1; i < ocnt; i++)
                if (of[i] <= of[sel]) sel = i;
            c = ocell[sel];
            for (int i = sel; i < ocnt - 1; i++) begin
                ocell[i] = ocell[i + 1];
                of[i] = of[i + 1];
            end
            ocnt--;
            if (shut[c]) continue;
            if (c == gl) begin
                done = 1;
                break;
            end
            shut[c] = 1;
            for (int d = 0; d < 4; d++) begin
                nx = c % Side + dx[d];
                ny = c / Side + dy[d];
                if (nx < 0 || ny < 0 || nx >= Side || ny >= Side) continue;
                nc = ny * Side + nx;
                if (shut[nc] || wall[nc]) continue;
                g = cost[c] + 1;
                if (seen[nc] && g >= cost[nc]) continue;
                if (ocnt >= OpenMax) continue;
                seen[nc] = 1;
                cost[nc] = g;
                from[nc] = t_dir'(d);
                ocell[ocnt] = nc;
                of[ocnt] = g + manh(nc, gl);
                ocnt++;
            end
        end
        if (!done) begin
            s.x = 3'd0;
            s.y = 3'd0;
            s.found = 1'b0;
            s.last = 1'b1;
            expected_steps = {expected_steps, s};
        end else begin
            len = 0;
            cur = gl;
            while (len < NCell) begin
                trail[len] = cur;
                len++;
                if (cur == st) break;
                nx = cur % Side - dx[from[cur]];
                ny = cur / Side - dy[from[cur]];
                if (nx < 0 || ny < 0 || nx >= Side || ny >= Side) break;
                cur = ny * Side + nx;
            end
            for (int k = 0; k < len; k++) begin
                s.x = 3'(trail[len - 1 - k] % Side);
                s.y = 3'(trail[len - 1 - k] / Side);
                s.found = 1'b1;
                s.last = (k + 1 == len);
                expected_steps = {expected_steps, s};
            end
        end
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic t_req rand_req(bit op);
        t_req r;
        r = ReqW'($urandom);
        r.op = op;
        return r;
    endfunction

    function automatic t_req wr(int x, int y, bit b);
        t_req r;
        r = rand_req(OpWrite);
        r.cx = 3'(x);
        r.cy = 3'(y);
        r.blk = b;
        return r;
    endfunction

    function automatic t_req qry(int sx, int sy, int gx, int gy);
        t_req r;
        r = rand_req(OpQuery);
        r.sx = 3'(sx);
        r.sy = 3'(sy);
        r.gx = 3'(gx);
        r.gy = 3'(gy);
        return r;
    endfunction

    // driver
    int  send_gap = 0;
    t_req cur_req;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                cur_req = pending_reqs.pop_front();
                if (cur_req.op == OpWrite)
                    wall[cur_req.cy * Side + cur_req.cx] = cur_req.blk;
                else
                    predict_path(cur_req);
                send_gap = gap_len();
            end
            if (!(i_valid && o_stall)) begin
                if (send_gap > 0 || pending_reqs.size() == 0) begin
                    if (send_gap > 0) send_gap = send_gap - 1;
                    i_valid <= 1'b0;
                end else begin
                    i_valid <= 1'b1;
                    i_op <= pending_reqs[0].op;
                    i_cell_x <= pending_reqs[0].cx;
                    i_cell_y <= pending_reqs[0].cy;
                    i_cell_blocked <= pending_reqs[0].blk;
                    i_start_x <= pending_reqs[0].sx;
                    i_start_y <= pending_reqs[0].sy;
                    i_goal_x <= pending_reqs[0].gx;
                    i_goal_y <= pending_reqs[0].gy;
                end
            end
        end
    end

    // monitor
    int    stall_left = 0;
    t_step want;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_steps.size() == 0) begin
                    $error("unexpected word x=%0d y=%0d", o_step_x, o_step_y);
                    errors++;
                end else begin
                    want = expected_steps.pop_front();
                    if (o_step_x !== want.x) begin
                        $error("step_x exp %0d got %0d", want.x, o_step_x);
                        errors++;
                    end
                    if (o_step_y !== want.y) begin
                        $error("step_y exp %0d got %0d", want.y, o_step_y);
                        errors++;
                    end
                    if (o_found !== want.found) begin
                        $error("found exp %0d got %0d", want.found, o_found);
                        errors++;
                    end
                    if (o_last !== want.last) begin
                        $error("last exp %0d got %0d", want.last, o_last);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left = stall_left - 1;
                i_stall <= 1'b1;
            end else begin
                stall_left = gap_len();
                i_stall <= (stall_left > 0);
            end
        end
    end

    initial begin
        int k;
        foreach (wall[i]) wall[i] = 0;
        // directed: empty map corners, start==goal, blocked goal/start, walls, no path
        add_req(qry(0, 0, 7, 7));
        add_req(qry(7, 7, 0, 0));
        add_req(qry(3, 4, 3, 4));
        add_req(wr(7, 7, 1));
        add_req(qry(0, 0, 7, 7));
        add_req(wr(0, 0, 1));
        add_req(qry(0, 0, 2, 0));
        add_req(wr(1, 0, 1));
        add_req(wr(0, 1, 1));
        add_req(qry(0, 0, 5, 5));
        add_req(qry(5, 5, 0, 0));
        for (int y = 0; y < 7; y++) add_req(wr(4, y, 1));
        add_req(qry(0, 3, 7, 0));
        add_req(qry(7, 0, 0, 6));
        add_req(wr(4, 7, 1));
        add_req(qry(2, 2, 6, 2));
        for (int i = 0; i < 340; i++) begin
            k = $urandom_range(0, 99);
            if (k < 45) add_req(wr($urandom_range(0, 7),
                    $urandom_range(0, 7), $urandom_range(0, 99) < 30));
            else if (k < 50) add_req(wr($urandom_range(0, 7),
                    $urandom_range(0, 7), 0));
            else add_req(rand_req(OpQuery));
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !i_valid);
        wait (expected_steps.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("grid_astar_path_finder: match");
        else
            $display("grid_astar_path_finder: mismatch");
        $finish;
    end

    always @(posedge i_clk) begin
        if (cycles > CycleLimit) begin
            $display("grid_astar_path_finder: mismatch");
            $finish;
        end
    end
endmodule
